>>> rtl/core/fte_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the allocation table engine
// no dependencies; imported by every other file of the block

package fte_pkg;

	// width used for byte offsets and bounds checks (32-bit cluster times 4, plus headroom)
	localparam int unsigned OFFW = 35;

	// action codes
	localparam logic [3:0] ACT_READ  = 4'd0;
	localparam logic [3:0] ACT_WRITE = 4'd1;
	localparam logic [3:0] ACT_CHAIN = 4'd2;
	localparam logic [3:0] ACT_COUNT = 4'd3;
	localparam logic [3:0] ACT_FIND  = 4'd4;
	localparam logic [3:0] ACT_ALLOC = 4'd5;
	localparam logic [3:0] ACT_CLEAR = 4'd6;
	localparam logic [3:0] ACT_FRAG  = 4'd7;
	localparam logic [3:0] ACT_CHECK = 4'd8;

	// configuration register indexes
	localparam logic REG_FAT_BYTES_USED = 1'b0;
	localparam logic REG_CLUSTER_COUNT  = 1'b1;

	// packing thresholds and end marks
	localparam logic [18:0] KIND32_MIN = 19'h10000;
	localparam logic [18:0] KIND16_MIN = 19'h01000;
	localparam logic [31:0] EOF32      = 32'h0FFFFFF8;
	localparam logic [31:0] EOF16      = 32'h0000FFF8;
	localparam logic [31:0] EOF12      = 32'h00000FF8;
	localparam logic [31:0] EOFW32     = 32'h0FFFFFFF;
	localparam logic [31:0] EOFW16     = 32'h0000FFFF;
	localparam logic [31:0] EOFW12     = 32'h00000FFF;
	localparam logic [20:0] MAX_ALLOC  = 21'd65536;

	typedef enum logic [1:0] {
		K12,
		K16,
		K32
	} kind_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [27:0] cluster;
		logic [31:0] entry_value;
		logic [20:0] limit;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [31:0] result_value;
		logic [16:0] extra_count;
	} rsp_t;

	typedef enum logic [5:0] {
		S_CLR,
		S_IDLE,
		S_DISP,
		S_DONE,
		S_EOFF,
		S_ERD,
		S_ERDW,
		S_ENX,
		S_EWR,
		S_RD_FIN,
		S_WR_FIN,
		S_CL_CHK,
		S_CL_TST,
		S_CL_EOF,
		S_CF_CHK,
		S_CF_TST,
		S_FF_CHK,
		S_FF_TST,
		S_AL_CHK,
		S_AL_TST,
		S_AL_W0,
		S_AL_LOOP,
		S_AL_LINK,
		S_AL_R1,
		S_AL_U1,
		S_AL_W2,
		S_AL_R2,
		S_AL_U2,
		S_AL_NEXT,
		S_AL_END,
		S_AL_FIN,
		S_CC_CHK,
		S_CC_WR,
		S_CC_NX,
		S_FG_CHK,
		S_FG_RD,
		S_FG_NX,
		S_CK_CHK,
		S_CK_TST,
		S_CK_INC
	} fsm_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CUR2,
		OP_CUR_INC,
		OP_CUR_NX,
		OP_CUR_NX_CNT,
		OP_CUR_SCAN,
		OP_CNT_INC,
		OP_RES_INC,
		OP_EXTRA_INC,
		OP_RES_CNT,
		OP_RES_CUR,
		OP_RES_NX,
		OP_CF_STEP,
		OP_SET_ERR,
		OP_WR_STAT,
		OP_ACC_CUR_ZERO,
		OP_ACC_CUR_IN,
		OP_ACC_CUR_EOFW,
		OP_ACC_PREV_CUR,
		OP_ACC_PREV_EOFW,
		OP_OFF,
		OP_NX,
		OP_SCAN_UPD,
		OP_AL_START,
		OP_AL_FOUND,
		OP_AL_NEXT,
		OP_AL_DONE,
		OP_FRAG
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       byte_rd;
		logic       byte_wr;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [3:0] action;
		kind_t      kind;
		logic       clr_busy;
		logic       inr;
		logic       cur_ge_cc;
		logic       cur_zero;
		logic       cur_ge_eof;
		logic       nx_zero;
		logic       nx_ge_eof;
		logic       nx_ge_cc;
		logic       cnt_ge_lim;
		logic       cnt_zero;
		logic       lim_bad;
	} dp_stat_t;

endpackage

>>> rtl/core/fte_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the allocation table engine
// depends on fte_pkg for the payload structs

interface fte_req_if import fte_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fte_rsp_if import fte_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/fte_dp.sv
`timescale 1ns / 1ps
// datapath: config registers, table byte memory with clearing pass, work registers
// depends on fte_pkg; driven by fte_ctrl through cmd_t, reports through dp_stat_t

module fte_dp import fte_pkg::*; #(
	parameter int unsigned FAT_BYTES = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [18:0] cfg_data,
	input  req_t        req_data,
	input  cmd_t        cmd,
	output dp_stat_t    st,
	output rsp_t        rsp_data
);

	localparam int unsigned AW  = $clog2(FAT_BYTES);
	localparam int unsigned AW1 = AW + 1;
	localparam logic [AW:0]     DEPTH   = AW1'(FAT_BYTES);
	localparam logic [AW-1:0]   LAST    = AW'(FAT_BYTES - 1);
	localparam logic [OFFW-1:0] DEPTH_W = OFFW'(FAT_BYTES);

	logic [18:0]   fbu_q;
	logic [16:0]   cc_q;
	logic [3:0]    act_q;
	logic [31:0]   cur_q, prev_q, scan_q, start_q, nx_q, acc_q, wval_q, inval_q;
	logic [20:0]   lim_q;
	logic [31:0]   cnt_q, res_q;
	logic [16:0]   extra_q;
	logic          err_q, have_q, inr_q;
	logic [AW:0]   off_q;
	logic [31:0]   word_q;
	logic [7:0]    rdata_q;
	logic          cap_q;
	logic [1:0]    cap_idx_q;
	logic [AW-1:0] clr_q;
	logic          clr_busy_q;
	logic [7:0]    mem_q [FAT_BYTES];

	kind_t         kind;
	logic [31:0]   eof, eofw, ent, wword;
	logic [15:0]   w12;
	logic [OFFW-1:0] sz, off_full, end_off;
	logic [2:0]    nb;
	logic          inr;
	logic [AW:0]   addr;
	logic          oob;
	logic [7:0]    wbyte;

	// packing and end marks from the configured size
	always_comb begin
		if (fbu_q >= KIND32_MIN) begin
			kind = K32;
		end else if (fbu_q >= KIND16_MIN) begin
			kind = K16;
		end else begin
			kind = K12;
		end
	end

	always_comb begin
		case (kind)
			K32: begin
				eof  = EOF32;
				eofw = EOFW32;
				off_full = {1'b0, acc_q, 2'b00};
				nb = 3'd4;
			end
			K16: begin
				eof  = EOF16;
				eofw = EOFW16;
				off_full = {2'b00, acc_q, 1'b0};
				nb = 3'd2;
			end
			default: begin
				eof  = EOF12;
				eofw = EOFW12;
				off_full = OFFW'(acc_q) + OFFW'(acc_q[31:1]);
				nb = 3'd1;
			end
		endcase
	end

	// bounds check against the usable size
	assign sz      = (OFFW'(fbu_q) < DEPTH_W) ? OFFW'(fbu_q) : DEPTH_W;
	assign end_off = off_full + OFFW'(nb);
	assign inr     = (end_off <= sz);

	// byte address of the current beat within the entry
	assign addr = off_q + AW1'(cmd.idx);
	assign oob  = (addr >= DEPTH);

	// entry value from the assembled bytes
	always_comb begin
		if (!inr_q) begin
			ent = '0;
		end else begin
			case (kind)
				K32:     ent = word_q;
				K16:     ent = {16'b0, word_q[15:0]};
				default: ent = acc_q[0] ? {20'b0, word_q[15:4]} : {20'b0, word_q[11:0]};
			endcase
		end
	end

	// write word, merging the neighbor nibble for packed entries
	assign w12   = acc_q[0] ? {wval_q[11:0], word_q[3:0]} : {word_q[15:12], wval_q[11:0]};
	assign wword = (kind == K12) ? {16'b0, w12} : wval_q;
	assign wbyte = wword[8*cmd.idx +: 8];

	// config registers, clearing pass, read capture flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbu_q      <= '0;
			cc_q       <= '0;
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
			cap_q      <= 1'b0;
			cap_idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FAT_BYTES_USED) begin
					fbu_q <= cfg_data;
				end else begin
					cc_q <= cfg_data[16:0];
				end
			end
			if (clr_busy_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
			cap_q     <= cmd.byte_rd;
			cap_idx_q <= cmd.idx;
		end
	end

	// table memory, single write port
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_q] <= '0;
		end else if (cmd.byte_wr && !oob) begin
			mem_q[addr[AW-1:0]] <= wbyte;
		end
	end

	// registered read, bytes past the store read as zero
	always_ff @(posedge clk) begin
		if (cmd.byte_rd) begin
			rdata_q <= oob ? 8'h00 : mem_q[addr[AW-1:0]];
		end
	end

	// assemble entry bytes little endian
	always_ff @(posedge clk) begin
		if (cap_q) begin
			word_q[8*cap_idx_q +: 8] <= rdata_q;
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				act_q   <= req_data.action;
				cur_q   <= {4'b0, req_data.cluster};
				inval_q <= req_data.entry_value;
				lim_q   <= req_data.limit;
				cnt_q   <= '0;
				res_q   <= '0;
				extra_q <= '0;
				err_q   <= 1'b0;
				have_q  <= 1'b0;
			end
			OP_CUR2:       cur_q <= 32'd2;
			OP_CUR_INC:    cur_q <= cur_q + 32'd1;
			OP_CUR_NX:     cur_q <= nx_q;
			OP_CUR_NX_CNT: begin
				cur_q <= nx_q;
				cnt_q <= cnt_q + 32'd1;
			end
			OP_CUR_SCAN:   cur_q <= scan_q;
			OP_CNT_INC:    cnt_q <= cnt_q + 32'd1;
			OP_RES_INC:    res_q <= res_q + 32'd1;
			OP_EXTRA_INC:  extra_q <= extra_q + 17'd1;
			OP_RES_CNT:    res_q <= cnt_q;
			OP_RES_CUR:    res_q <= cur_q;
			OP_RES_NX:     res_q <= nx_q;
			OP_CF_STEP: begin
				if (nx_q == '0) begin
					res_q <= res_q + 32'd1;
				end
				cur_q <= cur_q + 32'd1;
			end
			OP_SET_ERR: begin
				err_q   <= 1'b1;
				res_q   <= '0;
				extra_q <= '0;
			end
			OP_WR_STAT:    err_q <= !inr_q;
			OP_ACC_CUR_ZERO: begin
				acc_q  <= cur_q;
				wval_q <= '0;
			end
			OP_ACC_CUR_IN: begin
				acc_q  <= cur_q;
				wval_q <= inval_q;
			end
			OP_ACC_CUR_EOFW: begin
				acc_q  <= cur_q;
				wval_q <= eofw;
			end
			OP_ACC_PREV_CUR: begin
				acc_q  <= prev_q;
				wval_q <= cur_q;
			end
			OP_ACC_PREV_EOFW: begin
				acc_q  <= prev_q;
				wval_q <= eofw;
			end
			OP_OFF: begin
				off_q <= off_full[AW:0];
				inr_q <= inr;
			end
			OP_NX:         nx_q <= ent;
			OP_SCAN_UPD: begin
				if (nx_q == '0 && acc_q < scan_q) begin
					scan_q <= acc_q;
				end
			end
			OP_AL_START: begin
				start_q <= cur_q;
				scan_q  <= cur_q;
				prev_q  <= cur_q;
				cnt_q   <= 32'd1;
			end
			OP_AL_FOUND:   scan_q <= cur_q;
			OP_AL_NEXT: begin
				prev_q <= cur_q;
				cnt_q  <= cnt_q + 32'd1;
			end
			OP_AL_DONE: begin
				res_q   <= start_q;
				extra_q <= cnt_q[16:0];
			end
			OP_FRAG: begin
				if (have_q && cur_q != prev_q + 32'd1) begin
					res_q <= res_q + 32'd1;
				end
				prev_q <= cur_q;
				have_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// status toward the controller
	always_comb begin
		st.action     = act_q;
		st.kind       = kind;
		st.clr_busy   = clr_busy_q;
		st.inr        = inr;
		st.cur_ge_cc  = (cur_q >= {15'b0, cc_q});
		st.cur_zero   = (cur_q == '0);
		st.cur_ge_eof = (cur_q >= eof);
		st.nx_zero    = (nx_q == '0);
		st.nx_ge_eof  = (nx_q >= eof);
		st.nx_ge_cc   = (nx_q >= {15'b0, cc_q});
		st.cnt_ge_lim = (cnt_q >= {11'b0, lim_q});
		st.cnt_zero   = (cnt_q == '0);
		st.lim_bad    = (lim_q == '0) || (lim_q > MAX_ALLOC);
	end

	assign rsp_data.status       = err_q;
	assign rsp_data.result_value = res_q;
	assign rsp_data.extra_count  = extra_q;

endmodule

>>> rtl/core/fte_ctrl.sv
`timescale 1ns / 1ps
// controller: action sequencer with an entry access subroutine
// depends on fte_pkg; drives fte_dp through cmd_t

module fte_ctrl import fte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t st,
	output cmd_t     cmd
);

	fsm_t       state_q, state_d, ret_q, ret_d;
	logic       wr_q, wr_d;
	logic [1:0] k_q, k_d;
	logic [1:0] k_last;

	assign k_last = (st.kind == K32) ? 2'd3 : 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q   <= S_IDLE;
			wr_q    <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			wr_q    <= wr_d;
			k_q     <= k_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		wr_d    = wr_q;
		k_d     = k_q;
		case (state_q)
			S_CLR:  if (!st.clr_busy) state_d = S_IDLE;
			S_IDLE: if (req_valid) state_d = S_DISP;
			S_DISP: begin
				case (st.action)
					ACT_READ: begin
						state_d = S_EOFF; ret_d = S_RD_FIN; wr_d = 1'b0;
					end
					ACT_WRITE: begin
						state_d = S_EOFF; ret_d = S_WR_FIN; wr_d = 1'b1;
					end
					ACT_CHAIN: state_d = S_CL_CHK;
					ACT_COUNT: state_d = S_CF_CHK;
					ACT_FIND:  state_d = S_FF_CHK;
					ACT_ALLOC: state_d = st.lim_bad ? S_DONE : S_AL_CHK;
					ACT_CLEAR: state_d = S_CC_CHK;
					ACT_FRAG:  state_d = S_FG_CHK;
					ACT_CHECK: state_d = S_CK_CHK;
					default:   state_d = S_DONE;
				endcase
			end
			S_DONE: if (rsp_ready) state_d = S_IDLE;
			// entry access
			S_EOFF: begin
				k_d = '0;
				if (wr_q) begin
					if (!st.inr) begin
						state_d = ret_q;
					end else if (st.kind == K12) begin
						state_d = S_ERD;
					end else begin
						state_d = S_EWR;
					end
				end else begin
					state_d = S_ERD;
				end
			end
			S_ERD: begin
				if (k_q == k_last) begin
					state_d = S_ERDW;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			S_ERDW: begin
				k_d = '0;
				state_d = wr_q ? S_EWR : S_ENX;
			end
			S_ENX: state_d = ret_q;
			S_EWR: begin
				if (k_q == k_last) begin
					state_d = ret_q;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			S_RD_FIN: state_d = S_DONE;
			S_WR_FIN: state_d = S_DONE;
			// chain length
			S_CL_CHK: begin
				if (st.cnt_ge_lim) begin
					state_d = S_DONE;
				end else begin
					state_d = S_EOFF; ret_d = S_CL_TST; wr_d = 1'b0;
				end
			end
			S_CL_TST: state_d = st.nx_zero ? S_DONE : S_CL_EOF;
			S_CL_EOF: state_d = st.nx_ge_eof ? S_DONE : S_CL_CHK;
			// count free
			S_CF_CHK: begin
				if (st.cur_ge_cc) begin
					state_d = S_DONE;
				end else begin
					state_d = S_EOFF; ret_d = S_CF_TST; wr_d = 1'b0;
				end
			end
			S_CF_TST: state_d = S_CF_CHK;
			// find free
			S_FF_CHK: begin
				if (st.cur_ge_cc) begin
					state_d = S_DONE;
				end else begin
					state_d = S_EOFF; ret_d = S_FF_TST; wr_d = 1'b0;
				end
			end
			S_FF_TST: state_d = st.nx_zero ? S_DONE : S_FF_CHK;
			// allocate chain
			S_AL_CHK: begin
				if (st.cur_ge_cc) begin
					state_d = st.cnt_zero ? S_DONE : S_AL_END;
				end else begin
					state_d = S_EOFF; ret_d = S_AL_TST; wr_d = 1'b0;
				end
			end
			S_AL_TST: begin
				if (!st.nx_zero) begin
					state_d = S_AL_CHK;
				end else if (st.cnt_zero) begin
					state_d = S_AL_W0;
				end else begin
					state_d = S_AL_LINK;
				end
			end
			S_AL_W0: begin
				state_d = S_EOFF; ret_d = S_AL_LOOP; wr_d = 1'b1;
			end
			S_AL_LOOP: state_d = st.cnt_ge_lim ? S_AL_END : S_AL_CHK;
			S_AL_LINK: begin
				state_d = S_EOFF; ret_d = S_AL_R1; wr_d = 1'b1;
			end
			S_AL_R1: begin
				state_d = S_EOFF; ret_d = S_AL_U1; wr_d = 1'b0;
			end
			S_AL_U1: state_d = S_AL_W2;
			S_AL_W2: begin
				state_d = S_EOFF; ret_d = S_AL_R2; wr_d = 1'b1;
			end
			S_AL_R2: begin
				state_d = S_EOFF; ret_d = S_AL_U2; wr_d = 1'b0;
			end
			S_AL_U2:   state_d = S_AL_NEXT;
			S_AL_NEXT: state_d = S_AL_LOOP;
			S_AL_END: begin
				state_d = S_EOFF; ret_d = S_AL_FIN; wr_d = 1'b1;
			end
			S_AL_FIN: state_d = S_DONE;
			// clear chain
			S_CC_CHK: begin
				if (st.cur_zero || st.cur_ge_eof) begin
					state_d = S_DONE;
				end else begin
					state_d = S_EOFF; ret_d = S_CC_WR; wr_d = 1'b0;
				end
			end
			S_CC_WR: begin
				state_d = S_EOFF; ret_d = S_CC_NX; wr_d = 1'b1;
			end
			S_CC_NX: state_d = S_CC_CHK;
			// fragments
			S_FG_CHK: begin
				if (st.cnt_ge_lim || st.cur_zero || st.cur_ge_eof) begin
					state_d = S_DONE;
				end else begin
					state_d = S_FG_RD;
				end
			end
			S_FG_RD: begin
				state_d = S_EOFF; ret_d = S_FG_NX; wr_d = 1'b0;
			end
			S_FG_NX: state_d = S_FG_CHK;
			// check and repair
			S_CK_CHK: begin
				if (st.cur_ge_cc) begin
					state_d = S_DONE;
				end else begin
					state_d = S_EOFF; ret_d = S_CK_TST; wr_d = 1'b0;
				end
			end
			S_CK_TST: begin
				if (st.nx_zero || st.nx_ge_eof) begin
					state_d = S_CK_CHK;
				end else if (st.nx_ge_cc) begin
					state_d = S_EOFF; ret_d = S_CK_INC; wr_d = 1'b1;
				end else begin
					state_d = S_CK_INC;
				end
			end
			S_CK_INC: state_d = S_CK_CHK;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op      = OP_NONE;
		cmd.byte_rd = 1'b0;
		cmd.byte_wr = 1'b0;
		cmd.idx     = k_q;
		req_ready   = (state_q == S_IDLE);
		rsp_valid   = (state_q == S_DONE);
		case (state_q)
			S_IDLE: if (req_valid) cmd.op = OP_LOAD;
			S_DISP: begin
				case (st.action)
					ACT_READ:  cmd.op = OP_ACC_CUR_ZERO;
					ACT_WRITE: cmd.op = OP_ACC_CUR_IN;
					ACT_COUNT: cmd.op = OP_CUR2;
					ACT_FIND:  cmd.op = OP_CUR2;
					ACT_CHECK: cmd.op = OP_CUR2;
					ACT_ALLOC: cmd.op = st.lim_bad ? OP_SET_ERR : OP_CUR2;
					ACT_CHAIN: cmd.op = OP_NONE;
					ACT_CLEAR: cmd.op = OP_NONE;
					ACT_FRAG:  cmd.op = OP_NONE;
					default:   cmd.op = OP_SET_ERR;
				endcase
			end
			S_EOFF:   cmd.op = OP_OFF;
			S_ERD:    cmd.byte_rd = 1'b1;
			S_ENX:    cmd.op = OP_NX;
			S_EWR:    cmd.byte_wr = 1'b1;
			S_RD_FIN: cmd.op = OP_RES_NX;
			S_WR_FIN: cmd.op = OP_WR_STAT;
			S_CL_CHK: cmd.op = st.cnt_ge_lim ? OP_RES_CNT : OP_ACC_CUR_ZERO;
			S_CL_TST: cmd.op = st.nx_zero ? OP_SET_ERR : OP_CNT_INC;
			S_CL_EOF: cmd.op = st.nx_ge_eof ? OP_RES_CNT : OP_CUR_NX;
			S_CF_CHK: if (!st.cur_ge_cc) cmd.op = OP_ACC_CUR_ZERO;
			S_CF_TST: cmd.op = OP_CF_STEP;
			S_FF_CHK: cmd.op = st.cur_ge_cc ? OP_SET_ERR : OP_ACC_CUR_ZERO;
			S_FF_TST: cmd.op = st.nx_zero ? OP_RES_CUR : OP_CUR_INC;
			S_AL_CHK: begin
				if (st.cur_ge_cc) begin
					cmd.op = st.cnt_zero ? OP_SET_ERR : OP_NONE;
				end else begin
					cmd.op = OP_ACC_CUR_ZERO;
				end
			end
			S_AL_TST: begin
				if (!st.nx_zero) begin
					cmd.op = OP_CUR_INC;
				end else if (st.cnt_zero) begin
					cmd.op = OP_AL_START;
				end else begin
					cmd.op = OP_AL_FOUND;
				end
			end
			S_AL_W0:   cmd.op = OP_ACC_CUR_EOFW;
			S_AL_LOOP: if (!st.cnt_ge_lim) cmd.op = OP_CUR_SCAN;
			S_AL_LINK: cmd.op = OP_ACC_PREV_CUR;
			S_AL_U1:   cmd.op = OP_SCAN_UPD;
			S_AL_W2:   cmd.op = OP_ACC_CUR_EOFW;
			S_AL_U2:   cmd.op = OP_SCAN_UPD;
			S_AL_NEXT: cmd.op = OP_AL_NEXT;
			S_AL_END:  cmd.op = OP_ACC_PREV_EOFW;
			S_AL_FIN:  cmd.op = OP_AL_DONE;
			S_CC_CHK:  if (!(st.cur_zero || st.cur_ge_eof)) cmd.op = OP_ACC_CUR_ZERO;
			S_CC_NX:   cmd.op = OP_CUR_NX;
			S_FG_CHK: begin
				if (!(st.cnt_ge_lim || st.cur_zero || st.cur_ge_eof)) begin
					cmd.op = OP_FRAG;
				end
			end
			S_FG_RD:   cmd.op = OP_ACC_CUR_ZERO;
			S_FG_NX:   cmd.op = OP_CUR_NX_CNT;
			S_CK_CHK:  if (!st.cur_ge_cc) cmd.op = OP_ACC_CUR_ZERO;
			S_CK_TST: begin
				if (st.nx_zero || st.nx_ge_eof) begin
					cmd.op = OP_CUR_INC;
				end else if (st.nx_ge_cc) begin
					cmd.op = OP_RES_INC;
				end else begin
					cmd.op = OP_EXTRA_INC;
				end
			end
			S_CK_INC:  cmd.op = OP_CUR_INC;
			default: ;
		endcase
	end

	// no table access while the clearing pass owns the memory port
	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.byte_rd || cmd.byte_wr) |-> !st.clr_busy)
		else $error("table access during clearing pass");

	// an accepted beat is dispatched on the next cycle
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_DISP))
		else $error("accepted beat not dispatched");

	// nothing is accepted before the table is cleared
	a_ready_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !st.clr_busy)
		else $error("ready raised during clearing pass");

	// byte index stays within the entry width
	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.byte_rd || cmd.byte_wr) |-> (k_q <= k_last))
		else $error("byte index past entry width");

endmodule

>>> rtl/core/fat_table_engine.sv
`timescale 1ns / 1ps
// top level of the allocation table engine: controller plus datapath
// depends on fte_pkg, fte_if, fte_ctrl and fte_dp
//
// After reset the block sweeps the table memory to zero, one byte per cycle, and takes
// no request until the sweep is done; configuration writes are taken during that time. It then
// works on one request at a time over a single byte-wide memory port. Every entry access
// first computes the byte offset and then moves one byte at a time; reads then wait for the
// read data and latch the entry. Packed 12-bit writes read the entry first to merge the
// neighbor nibble, and a write to an entry out of range skips the byte accesses. Count,
// find and check pay one entry read per cluster scanned, and one more write for a repaired
// entry; chain walks, fragment counts and clears pay per link, and allocation pays per
// cluster handed out, plus one entry read per occupied cluster skipped.

module fat_table_engine import fte_pkg::*; #(
	parameter int unsigned FAT_BYTES = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [18:0] cfg_data,
	fte_req_if.sink     req,
	fte_rsp_if.source   rsp
);

	cmd_t     cmd;
	dp_stat_t st;
	rsp_t     rsp_data;

	// sequencer
	fte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// table memory and work registers
	fte_dp #(
		.FAT_BYTES (FAT_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req.data),
		.cmd       (cmd),
		.st        (st),
		.rsp_data  (rsp_data)
	);

	assign rsp.data = rsp_data;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for fat_table_engine: random and directed requests, own table model
// depends on fte_pkg, fte_if and the fat_table_engine rtl

module tb;
	import fte_pkg::*;

	localparam int unsigned TABLE_BYTES = 262144;

	// model of the table plus the queue of responses it predicts
	class fat_scoreboard;
		bit [7:0]  table_mem [TABLE_BYTES];
		bit [18:0] vol_bytes;
		bit [16:0] vol_count;
		bit [31:0] rescan_from;
		rsp_t      pending_rsp [$];
		int        mismatches;

		function void write_reg(logic idx, bit [18:0] value);
			if (idx == REG_FAT_BYTES_USED)
				vol_bytes = value;
			else
				vol_count = value[16:0];
		endfunction

		function kind_t packing();
			if (vol_bytes >= KIND32_MIN) return K32;
			if (vol_bytes >= KIND16_MIN) return K16;
			return K12;
		endfunction

		function bit [31:0] end_mark();
			case (packing())
				K32: return EOF32;
				K16: return EOF16;
				default: return EOF12;
			endcase
		endfunction

		function bit [31:0] end_fill();
			case (packing())
				K32: return EOFW32;
				K16: return EOFW16;
				default: return EOFW12;
			endcase
		endfunction

		function bit [7:0] peek(longint unsigned i);
			return (i < TABLE_BYTES) ? table_mem[i] : 8'h00;
		endfunction

		function void poke(longint unsigned i, bit [7:0] v);
			if (i < TABLE_BYTES) table_mem[i] = v;
		endfunction

		// offset of an entry, and whether it lies inside the usable size
		function bit locate(bit [31:0] c, output longint unsigned off);
			longint unsigned sz;
			sz = (vol_bytes < TABLE_BYTES) ? vol_bytes : TABLE_BYTES;
			case (packing())
				K32: begin
					off = longint'(c) * 4;
					return off + 4 <= sz;
				end
				K16: begin
					off = longint'(c) * 2;
					return off + 2 <= sz;
				end
				default: begin
					off = longint'(c) + longint'(c >> 1);
					return off + 1 <= sz;
				end
			endcase
		endfunction

		function bit [31:0] get_entry(bit [31:0] c);
			longint unsigned off;
			bit [15:0] w;
			if (!locate(c, off)) return 0;
			case (packing())
				K32: return {peek(off + 3), peek(off + 2), peek(off + 1), peek(off)};
				K16: return {16'h0, peek(off + 1), peek(off)};
				default: begin
					w = {peek(off + 1), peek(off)};
					return c[0] ? {20'h0, w[15:4]} : {20'h0, w[11:0]};
				end
			endcase
		endfunction

		function bit put_entry(bit [31:0] c, bit [31:0] v);
			longint unsigned off;
			bit [15:0] w;
			if (!locate(c, off)) return 0;
			case (packing())
				K32: begin
					poke(off, v[7:0]);
					poke(off + 1, v[15:8]);
					poke(off + 2, v[23:16]);
					poke(off + 3, v[31:24]);
				end
				K16: begin
					poke(off, v[7:0]);
					poke(off + 1, v[15:8]);
				end
				default: begin
					w = {peek(off + 1), peek(off)};
					if (c[0]) w = {v[11:0], w[3:0]};
					else w = {w[15:12], v[11:0]};
					poke(off, w[7:0]);
					poke(off + 1, w[15:8]);
				end
			endcase
			return 1;
		endfunction

		function bit lowest_free(bit [31:0] from, output bit [31:0] found);
			bit [31:0] c;
			found = 0;
			for (c = (from < 2) ? 2 : from; c < vol_count; c++)
				if (get_entry(c) == 0) begin
					found = c;
					return 1;
				end
			return 0;
		endfunction

		// allocation store; an entry that ends up free pulls the scan back
		function void link_entry(bit [31:0] c, bit [31:0] v);
			void'(put_entry(c, v));
			if (get_entry(c) == 0 && c < rescan_from) rescan_from = c;
		endfunction

		function void note_request(req_t r);
			rsp_t      e;
			bit [31:0] eof, c, nx, prev, n, start;
			bit        have_prev;
			e = '0;
			eof = end_mark();
			case (r.action)
				ACT_READ: e.result_value = get_entry({4'h0, r.cluster});
				ACT_WRITE: e.status = !put_entry({4'h0, r.cluster}, r.entry_value);
				ACT_CHAIN: begin
					n = 0;
					c = {4'h0, r.cluster};
					while (n < r.limit) begin
						nx = get_entry(c);
						if (nx == 0) begin
							e.status = 1;
							break;
						end
						n++;
						if (nx >= eof) break;
						c = nx;
					end
					e.result_value = e.status ? 0 : n;
				end
				ACT_COUNT: begin
					n = 0;
					for (c = 2; c < vol_count; c++)
						if (get_entry(c) == 0) n++;
					e.result_value = n;
				end
				ACT_FIND: begin
					if (!lowest_free(2, c)) e.status = 1;
					else e.result_value = c;
				end
				ACT_ALLOC: begin
					if (r.limit == 0 || r.limit > MAX_ALLOC || !lowest_free(2, start)) begin
						e.status = 1;
					end else begin
						rescan_from = start;
						link_entry(start, end_fill());
						prev = start;
						n = 1;
						while (n < r.limit) begin
							if (!lowest_free(rescan_from, nx)) break;
							rescan_from = nx;
							link_entry(prev, nx);
							link_entry(nx, end_fill());
							prev = nx;
							n++;
						end
						link_entry(prev, end_fill());
						e.result_value = start;
						e.extra_count = n[16:0];
					end
				end
				ACT_CLEAR: begin
					c = {4'h0, r.cluster};
					while (c != 0 && c < eof) begin
						nx = get_entry(c);
						void'(put_entry(c, 0));
						c = nx;
					end
				end
				ACT_FRAG: begin
					n = 0;
					prev = 0;
					have_prev = 0;
					c = {4'h0, r.cluster};
					for (int unsigned s = 0; s < r.limit && c != 0 && c < eof; s++) begin
						if (have_prev && c != prev + 1) e.result_value++;
						prev = c;
						have_prev = 1;
						c = get_entry(c);
					end
				end
				ACT_CHECK: begin
					for (c = 2; c < vol_count; c++) begin
						nx = get_entry(c);
						if (nx == 0 || nx >= eof) continue;
						if (nx >= vol_count) begin
							e.result_value++;
							void'(put_entry(c, 0));
						end else begin
							e.extra_count++;
						end
					end
				end
				default: e.status = 1;
			endcase
			pending_rsp.push_back(e);
		endfunction

		task report(string msg);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_response(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				report("response beat with nothing outstanding");
				return;
			end
			e = pending_rsp.pop_front();
			if (got.status !== e.status)
				report($sformatf("status %0b, want %0b", got.status, e.status));
			if (got.result_value !== e.result_value)
				report($sformatf("result_value %0h, want %0h", got.result_value,
					e.result_value));
			if (got.extra_count !== e.extra_count)
				report($sformatf("extra_count %0h, want %0h", got.extra_count,
					e.extra_count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [18:0] cfg_data;

	fte_req_if req ();
	fte_rsp_if rsp ();

	fat_table_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	fat_scoreboard sb;
	bit [16:0]     cur_clusters;
	bit            roomy;

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic write_cfg(logic idx, bit [18:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one request beat; valid stays high when the next beat follows with no gap
	task automatic send(req_t r, int unsigned gap);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
	endtask

	task automatic send_fields(logic [3:0] act, logic [27:0] cl, logic [31:0] v,
			logic [20:0] lim);
		req_t r;
		r.action = act;
		r.cluster = cl;
		r.entry_value = v;
		r.limit = lim;
		send(r, pick_gap());
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_volume(bit [18:0] bytes, bit [16:0] clusters, bit fits);
		drain();
		write_cfg(REG_FAT_BYTES_USED, bytes);
		write_cfg(REG_CLUSTER_COUNT, {2'b00, clusters});
		cur_clusters = clusters;
		roomy = fits;
	endtask

	function automatic req_t rand_req();
		req_t        r;
		int unsigned p;
		p = $urandom_range(0, 99);
		r.action = (p < 4) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		p = $urandom_range(0, 99);
		if (p < 80) r.cluster = 28'($urandom_range(0, cur_clusters + 3));
		else if (p < 90) r.cluster = 28'($urandom_range(0, 3));
		else r.cluster = 28'($urandom());
		p = $urandom_range(0, 99);
		if (p < 40) r.entry_value = $urandom_range(0, cur_clusters + 3);
		else if (p < 55) begin
			case ($urandom_range(0, 5))
				0: r.entry_value = EOF12;
				1: r.entry_value = EOFW16;
				2: r.entry_value = EOF32;
				3: r.entry_value = EOFW32;
				4: r.entry_value = EOF16 - 1;
				default: r.entry_value = EOFW12;
			endcase
		end else if (p < 65) r.entry_value = 0;
		else r.entry_value = $urandom();
		p = $urandom_range(0, 99);
		case (r.action)
			ACT_CHAIN, ACT_FRAG: r.limit = 21'($urandom_range(0, 24));
			ACT_ALLOC: begin
				if (p < 85) r.limit = 21'($urandom_range(1, 8));
				else if (p < 90) r.limit = 0;
				else if (p < 95) r.limit = roomy ? MAX_ALLOC : 21'd5;
				else r.limit = 21'($urandom_range(65537, 2097151));
			end
			default: r.limit = 21'($urandom());
		endcase
		return r;
	endfunction

	task automatic random_burst(int unsigned n);
		repeat (n) send(rand_req(), pick_gap());
	endtask

	// response side: random stalls, with some stretches of none
	initial begin
		int unsigned stall;
		bit          calm;
		stall = 0;
		calm = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) sb.check_response(rsp.data);
			if ($urandom_range(0, 199) == 0) calm = !calm;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				stall--;
			end else begin
				rsp.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	// stimulus
	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FAT_BYTES_USED;
		cfg_data = '0;
		req.valid = 1'b0;
		req.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: nothing in range, no clusters
		send_fields(ACT_READ, 28'h0, 32'h0, 21'h0);
		send_fields(ACT_WRITE, 28'h0, 32'h123, 21'h0);
		send_fields(ACT_FIND, 28'h0, 32'h0, 21'h0);
		send_fields(ACT_ALLOC, 28'h0, 32'h0, 21'd1);

		// 12-bit packing, directed corners
		set_volume(19'd3000, 17'd40, 1);
		send_fields(ACT_WRITE, 28'd3, 32'hFFFFFFFF, 21'h1FFFFF);
		send_fields(ACT_WRITE, 28'd4, 32'd5, 21'h0);
		send_fields(ACT_READ, 28'd3, 32'h0, 21'h0);
		send_fields(ACT_READ, 28'hFFFFFFF, 32'h0, 21'h0);
		send_fields(ACT_WRITE, 28'hFFFFFFF, 32'h1, 21'h0);
		send_fields(ACT_WRITE, 28'd1999, 32'h0FFF, 21'h0);
		send_fields(ACT_WRITE, 28'd2000, 32'h1, 21'h0);
		send_fields(ACT_ALLOC, 28'd0, 32'h0, 21'd4);
		send_fields(ACT_ALLOC, 28'd0, 32'h0, 21'd0);
		send_fields(ACT_ALLOC, 28'd0, 32'h0, 21'd65537);
		send_fields(ACT_CHAIN, 28'd2, 32'h0, 21'd10);
		send_fields(ACT_CHAIN, 28'd39, 32'h0, 21'd10);
		send_fields(ACT_FRAG, 28'd2, 32'h0, 21'd10);
		send_fields(ACT_WRITE, 28'd10, 32'd500, 21'h0);
		send_fields(ACT_CHECK, 28'd0, 32'h0, 21'h0);
		send_fields(ACT_COUNT, 28'd0, 32'h0, 21'h0);
		send_fields(ACT_CLEAR, 28'd2, 32'h0, 21'h0);
		send_fields(ACT_ALLOC, 28'd0, 32'h0, MAX_ALLOC);
		send_fields(ACT_FIND, 28'd0, 32'h0, 21'h0);
		send_fields(4'd15, 28'd2, 32'h0, 21'h0);
		random_burst(330);

		// 16-bit packing
		set_volume(19'd8192, 17'd48, 1);
		random_burst(330);

		// largest table, 32-bit entries
		set_volume(19'd262144, 17'd64, 1);
		send_fields(ACT_WRITE, 28'd65535, 32'hA5A5A5A5, 21'h0);
		send_fields(ACT_READ, 28'd65535, 32'h0, 21'h0);
		send_fields(ACT_WRITE, 28'd65536, 32'h1, 21'h0);
		random_burst(330);

		// packing boundaries
		set_volume(19'd4095, 17'd48, 1);
		random_burst(200);
		set_volume(19'd65535, 17'd48, 1);
		random_burst(200);
		set_volume(19'd65536, 17'd32, 1);
		random_burst(200);

		// volume larger than the table holds
		set_volume(19'd100, 17'd80, 0);
		random_burst(200);

		// full cluster count, one scan only
		set_volume(19'd262144, 17'd65536, 1);
		send_fields(ACT_COUNT, 28'd0, 32'h0, 21'h0);
		send_fields(ACT_ALLOC, 28'd0, 32'h0, 21'd3);
		send_fields(ACT_FIND, 28'd0, 32'h0, 21'h0);

		drain();
		if (sb.mismatches == 0)
			$display("fat_table_engine test passed");
		else
			$display("fat_table_engine test failed");
		$finish;
	end

	// watchdog
	initial begin
		#200ms;
		$display("fat_table_engine test failed");
		$finish;
	end

endmodule
